>>> hw/rtl/ucjk_pkg.sv
// ----------------------------------------------------------------------------
// ucjk_pkg
// Shared widths, sequence codes and code point class tests for the UTF-8
// CJK text counter.
// ----------------------------------------------------------------------------
package ucjk_pkg;

	localparam int BYTE_W         = 8;
	localparam int CP_W           = 21;
	localparam int OUT_W          = 32;
	localparam int EXP_W          = 2;
	localparam int SEQ_W          = 3;
	localparam int COUNT_BITS_DEF = 32;
	localparam int PUNCT_N        = 33;

	// Length of the sequence under decode
	localparam logic [SEQ_W-1:0] SEQ_NONE  = 3'd0;
	localparam logic [SEQ_W-1:0] SEQ_TWO   = 3'd2;
	localparam logic [SEQ_W-1:0] SEQ_THREE = 3'd3;
	localparam logic [SEQ_W-1:0] SEQ_FOUR  = 3'd4;

	typedef logic [CP_W-1:0] cp_t;

	localparam logic [15:0] PUNCT_LIST [PUNCT_N] = '{
		16'h3001, 16'h3002, 16'hFF0C, 16'hFF1B, 16'hFF1A, 16'hFF01, 16'hFF1F,
		16'h201C, 16'h201D, 16'h2018, 16'h2019, 16'hFF08, 16'hFF09, 16'h3010,
		16'h3011, 16'h300A, 16'h300B, 16'h2014, 16'h2026, 16'h00B7, 16'h300C,
		16'h300D, 16'h300E, 16'h300F, 16'h3014, 16'h3015, 16'h3016, 16'h3017,
		16'h301A, 16'h301B, 16'h3000, 16'hFFE5, 16'h203B
	};

	// Reject overlong forms, surrogates and values beyond the Unicode range
	function automatic logic seq_ok(input logic [SEQ_W-1:0] len, input cp_t c);
		logic ok;
		unique case (len)
			SEQ_TWO:   ok = (c >= 21'h80);
			SEQ_THREE: ok = (c >= 21'h800) && !((c >= 21'hD800) && (c <= 21'hDFFF));
			SEQ_FOUR:  ok = (c >= 21'h10000) && (c <= 21'h10FFFF);
			default:   ok = 1'b0;
		endcase
		return ok;
	endfunction

	// CJK unified ideograph blocks
	function automatic logic is_ideo(input cp_t c);
		return ((c >= 21'h4E00)  && (c <= 21'h9FFF))  ||
		       ((c >= 21'h3400)  && (c <= 21'h4DBF))  ||
		       ((c >= 21'h20000) && (c <= 21'h2A6DF)) ||
		       ((c >= 21'h2A700) && (c <= 21'h2B73F)) ||
		       ((c >= 21'h2B740) && (c <= 21'h2B81F)) ||
		       ((c >= 21'h2B820) && (c <= 21'h2CEAF)) ||
		       ((c >= 21'h2CEB0) && (c <= 21'h2EBE0)) ||
		       ((c >= 21'h2F800) && (c <= 21'h2FA1F));
	endfunction

	// CJK punctuation: all entries lie in the basic plane
	function automatic logic is_punct(input cp_t c);
		logic hit;
		hit = 1'b0;
		for (int i = 0; i < PUNCT_N; i++) begin
			if (c[15:0] == PUNCT_LIST[i])
				hit = 1'b1;
		end
		return hit && (c[CP_W-1:16] == '0);
	endfunction

	// ASCII letters, digits and apostrophe
	function automatic logic is_word(input cp_t c);
		return ((c >= 21'h61) && (c <= 21'h7A)) ||
		       ((c >= 21'h41) && (c <= 21'h5A)) ||
		       ((c >= 21'h30) && (c <= 21'h39)) ||
		       (c == 21'h27);
	endfunction

endpackage

>>> hw/rtl/utf8_cjk_text_counter_unit.sv
// ----------------------------------------------------------------------------
// utf8_cjk_text_counter_unit
// Decodes a UTF-8 byte stream with full validation and counts CJK ideographs,
// CJK punctuation, ASCII words, word characters and code points per string.
// ----------------------------------------------------------------------------
//
//  channel   handshake               payload
//  -------   ---------------------   ----------------------------------------
//  byte      byte_valid / byte_stall byte_value, last_byte
//  count     count_valid/count_stall ideograph_count, punctuation_count,
//                                    word_count, word_char_count,
//                                    codepoint_count
//
//  One byte per cycle while byte_stall is low. A byte sits in the input register,
//  where it is decoded and the counters are updated; the counts of a string
//  are loaded into the output register when its last byte leaves the input register.
//  A pending result in the output register does not block ordinary bytes;
//  only a further last byte waits, stalling the byte channel while the
//  count channel is stalled.
//  Reset clears the decoder, the counters and both valid flags.
//
module utf8_cjk_text_counter_unit
	import ucjk_pkg::*;
#(
	parameter int COUNT_BITS = COUNT_BITS_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             byte_valid,
	output logic             byte_stall,
	input  logic [BYTE_W-1:0] byte_value,
	input  logic             last_byte,
	output logic             count_valid,
	input  logic             count_stall,
	output logic [OUT_W-1:0] ideograph_count,
	output logic [OUT_W-1:0] punctuation_count,
	output logic [OUT_W-1:0] word_count,
	output logic [OUT_W-1:0] word_char_count,
	output logic [OUT_W-1:0] codepoint_count
);

	typedef logic [COUNT_BITS-1:0] cnt_t;

	function automatic cnt_t sat_inc(input cnt_t v, input logic en);
		return (en && !(&v)) ? v + COUNT_BITS'(1) : v;
	endfunction

	// Input register
	logic              valid_s1;
	logic [BYTE_W-1:0] byte_s1;
	logic              last_s1;

	// Decoder and counter state
	cp_t              part_q;
	logic [EXP_W-1:0] exp_q;
	logic [SEQ_W-1:0] len_q;
	logic             inside_q;
	cnt_t             ideo_q, punct_q, words_q, wchars_q, total_q;

	// Result register
	logic             count_valid_q;
	logic [OUT_W-1:0] ideo_out_q, punct_out_q, words_out_q, wchars_out_q, total_out_q;

	cp_t              part_d;
	logic [EXP_W-1:0] exp_d;
	logic [SEQ_W-1:0] len_d;
	logic             inside_d;
	cnt_t             ideo_d, punct_d, words_d, wchars_d, total_d;
	cp_t              cp;
	logic             cp_ok;
	logic             hit_ideo, hit_punct, hit_word;
	logic             proceed;
	logic             byte_take;

	// Advance the held byte unless it closes a string and the result slot is blocked
	assign proceed    = valid_s1 && (!last_s1 || !count_valid_q || !count_stall);
	assign byte_stall = valid_s1 && !proceed;
	assign byte_take  = byte_valid && !byte_stall;

	// Decode one byte against the partial sequence
	always_comb begin
		part_d = part_q;
		exp_d  = exp_q;
		len_d  = len_q;
		cp     = {{(CP_W-BYTE_W){1'b0}}, byte_s1};
		cp_ok  = 1'b0;
		if ((exp_q != '0) && (byte_s1[7:6] == 2'b10)) begin
			part_d = {part_q[CP_W-7:0], byte_s1[5:0]};
			exp_d  = exp_q - EXP_W'(1);
			if (exp_q == EXP_W'(1)) begin
				cp     = part_d;
				cp_ok  = seq_ok(len_q, part_d);
				part_d = '0;
				len_d  = SEQ_NONE;
			end
		end else begin
			// Drop any unfinished sequence, then treat the byte as a start byte
			part_d = '0;
			exp_d  = '0;
			len_d  = SEQ_NONE;
			priority if (!byte_s1[7]) begin
				cp_ok = 1'b1;
			end else if (byte_s1[7:5] == 3'b110) begin
				part_d = {{(CP_W-5){1'b0}}, byte_s1[4:0]};
				exp_d  = EXP_W'(1);
				len_d  = SEQ_TWO;
			end else if (byte_s1[7:4] == 4'b1110) begin
				part_d = {{(CP_W-4){1'b0}}, byte_s1[3:0]};
				exp_d  = EXP_W'(2);
				len_d  = SEQ_THREE;
			end else if (byte_s1[7:3] == 5'b11110) begin
				part_d = {{(CP_W-3){1'b0}}, byte_s1[2:0]};
				exp_d  = EXP_W'(3);
				len_d  = SEQ_FOUR;
			end else begin
				cp_ok = 1'b0;
			end
		end
	end

	// Classify the finished code point and bump the counters
	always_comb begin
		hit_ideo  = cp_ok && is_ideo(cp);
		hit_punct = cp_ok && !hit_ideo && is_punct(cp);
		hit_word  = cp_ok && !hit_ideo && !hit_punct && is_word(cp);
		inside_d  = cp_ok ? hit_word : inside_q;
		total_d   = sat_inc(total_q, cp_ok);
		ideo_d    = sat_inc(ideo_q, hit_ideo);
		punct_d   = sat_inc(punct_q, hit_punct);
		wchars_d  = sat_inc(wchars_q, hit_word);
		words_d   = sat_inc(words_q, hit_word && !inside_q);
	end

	// Hold a transferred byte until it is processed
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (byte_take) begin
			valid_s1 <= 1'b1;
		end else if (proceed) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (byte_take) begin
			byte_s1 <= byte_value;
			last_s1 <= last_byte;
		end
	end

	// Update decoder state; clear everything at the end of a string
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			part_q   <= '0;
			exp_q    <= '0;
			len_q    <= SEQ_NONE;
			inside_q <= 1'b0;
			ideo_q   <= '0;
			punct_q  <= '0;
			words_q  <= '0;
			wchars_q <= '0;
			total_q  <= '0;
		end else if (proceed) begin
			if (last_s1) begin
				part_q   <= '0;
				exp_q    <= '0;
				len_q    <= SEQ_NONE;
				inside_q <= 1'b0;
				ideo_q   <= '0;
				punct_q  <= '0;
				words_q  <= '0;
				wchars_q <= '0;
				total_q  <= '0;
			end else begin
				part_q   <= part_d;
				exp_q    <= exp_d;
				len_q    <= len_d;
				inside_q <= inside_d;
				ideo_q   <= ideo_d;
				punct_q  <= punct_d;
				words_q  <= words_d;
				wchars_q <= wchars_d;
				total_q  <= total_d;
			end
		end
	end

	// Result valid: set on a finished string, drop once the transfer is taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_valid_q <= 1'b0;
		end else if (proceed && last_s1) begin
			count_valid_q <= 1'b1;
		end else if (!count_stall) begin
			count_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (proceed && last_s1) begin
			ideo_out_q   <= OUT_W'(ideo_d);
			punct_out_q  <= OUT_W'(punct_d);
			words_out_q  <= OUT_W'(words_d);
			wchars_out_q <= OUT_W'(wchars_d);
			total_out_q  <= OUT_W'(total_d);
		end
	end

	assign count_valid       = count_valid_q;
	assign ideograph_count   = ideo_out_q;
	assign punctuation_count = punct_out_q;
	assign word_count        = words_out_q;
	assign word_char_count   = wchars_out_q;
	assign codepoint_count   = total_out_q;

	// Checks
	a_clear_after_last: assert property (@(posedge clk) disable iff (!arst_n)
		(proceed && last_s1) |=> (exp_q == '0 && !inside_q && total_q == '0))
		else $error("decoder state not cleared after end of string");

	a_ideo_le_total: assert property (@(posedge clk) disable iff (!arst_n)
		(ideo_q <= total_q && punct_q <= total_q && wchars_q <= total_q))
		else $error("class count exceeds code point count");

	a_words_le_chars: assert property (@(posedge clk) disable iff (!arst_n)
		(words_q <= wchars_q))
		else $error("word count exceeds word character count");

	a_len_matches_exp: assert property (@(posedge clk) disable iff (!arst_n)
		(exp_q != '0) |-> (len_q > SEQ_W'(exp_q)))
		else $error("sequence length and pending byte count disagree");

	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		byte_stall |-> (last_s1 && count_valid_q && count_stall))
		else $error("byte channel stalled without a blocked result");

endmodule

>>> tb/sv/tb_utf8_cjk_text_counter_unit.sv
// ----------------------------------------------------------------------------
// tb_utf8_cjk_text_counter_unit
// Streams UTF-8 strings through the counter and checks each string's five
// counts against a behavioural decoder held in the testbench. Covers edge
// bytes, malformed sequences, three idle mixes and a long count hold-off.
// ----------------------------------------------------------------------------
module tb_utf8_cjk_text_counter_unit;
	import ucjk_pkg::*;

	localparam int QUIET_LIMIT = 2000;
	localparam int HOLD_CYCLES = 300;
	localparam int PHASE_BYTES = 150;

	// Slots of one count set, in port order
	typedef enum int {T_IDEO, T_PUNCT, T_WORDS, T_WCHARS, T_TOTAL} tally_e;
	typedef logic [4:0][OUT_W-1:0] tally_set_t;

	localparam logic [CP_W-1:0] IDEO_LO [8] = '{
		21'h4E00, 21'h3400, 21'h20000, 21'h2A700,
		21'h2B740, 21'h2B820, 21'h2CEB0, 21'h2F800
	};
	localparam logic [CP_W-1:0] IDEO_HI [8] = '{
		21'h9FFF, 21'h4DBF, 21'h2A6DF, 21'h2B73F,
		21'h2B81F, 21'h2CEAF, 21'h2EBE0, 21'h2FA1F
	};
	localparam logic [15:0] HAN_PUNCT [PUNCT_N] = '{
		16'h3001, 16'h3002, 16'hFF0C, 16'hFF1B, 16'hFF1A, 16'hFF01, 16'hFF1F,
		16'h201C, 16'h201D, 16'h2018, 16'h2019, 16'hFF08, 16'hFF09, 16'h3010,
		16'h3011, 16'h300A, 16'h300B, 16'h2014, 16'h2026, 16'h00B7, 16'h300C,
		16'h300D, 16'h300E, 16'h300F, 16'h3014, 16'h3015, 16'h3016, 16'h3017,
		16'h301A, 16'h301B, 16'h3000, 16'hFFE5, 16'h203B
	};
	localparam logic [CP_W-1:0] PLANE_EDGES [8] = '{
		21'h80, 21'h7FF, 21'h800, 21'hD7FF, 21'hE000, 21'hFFFF, 21'h10000, 21'h10FFFF
	};

	logic              clk;
	logic              arst_n;
	logic              byte_valid;
	logic              byte_stall;
	logic [BYTE_W-1:0] byte_value;
	logic              last_byte;
	logic              count_valid;
	logic              count_stall;
	logic [OUT_W-1:0]  ideograph_count;
	logic [OUT_W-1:0]  punctuation_count;
	logic [OUT_W-1:0]  word_count;
	logic [OUT_W-1:0]  word_char_count;
	logic [OUT_W-1:0]  codepoint_count;

	// Decoder state mirrored by the predictor
	logic [CP_W-1:0]  dec_cp;
	logic [EXP_W-1:0] dec_left;
	logic [SEQ_W-1:0] dec_len;
	logic             dec_in_word;
	tally_set_t       running_tally;

	tally_set_t        expected_counts [$];
	logic [BYTE_W-1:0] str_bytes [$];

	int send_idle_pct;
	int recv_idle_pct;
	int hold_left;
	int quiet_cycles;
	int mismatches;
	int bytes_taken;
	int strings_sent;
	int counts_checked;

	utf8_cjk_text_counter_unit dut (
		.clk               (clk),
		.arst_n            (arst_n),
		.byte_valid        (byte_valid),
		.byte_stall        (byte_stall),
		.byte_value        (byte_value),
		.last_byte         (last_byte),
		.count_valid       (count_valid),
		.count_stall       (count_stall),
		.ideograph_count   (ideograph_count),
		.punctuation_count (punctuation_count),
		.word_count        (word_count),
		.word_char_count   (word_char_count),
		.codepoint_count   (codepoint_count)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// ------------------------------------------------------------------
	// Predictor
	// ------------------------------------------------------------------

	function automatic logic cp_is_ideograph(input logic [CP_W-1:0] c);
		logic hit;
		hit = 1'b0;
		for (int i = 0; i < 8; i++)
			if (c >= IDEO_LO[i] && c <= IDEO_HI[i])
				hit = 1'b1;
		return hit;
	endfunction

	function automatic logic cp_is_han_punct(input logic [CP_W-1:0] c);
		logic hit;
		hit = 1'b0;
		for (int i = 0; i < PUNCT_N; i++)
			if (c == {5'd0, HAN_PUNCT[i]})
				hit = 1'b1;
		return hit;
	endfunction

	function automatic logic cp_is_word_char(input logic [CP_W-1:0] c);
		return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") ||
		       (c >= "0" && c <= "9") || c == 21'h27;
	endfunction

	// Saturating increment of one tally slot
	function automatic void bump_tally(input tally_e k);
		if (running_tally[k] != '1)
			running_tally[k] = running_tally[k] + 1'b1;
	endfunction

	// Count one valid code point in its class and track word runs
	function automatic void count_codepoint(input logic [CP_W-1:0] c);
		bump_tally(T_TOTAL);
		if (cp_is_ideograph(c)) begin
			bump_tally(T_IDEO);
			dec_in_word = 1'b0;
		end else if (cp_is_han_punct(c)) begin
			bump_tally(T_PUNCT);
			dec_in_word = 1'b0;
		end else if (cp_is_word_char(c)) begin
			if (!dec_in_word) begin
				bump_tally(T_WORDS);
				dec_in_word = 1'b1;
			end
			bump_tally(T_WCHARS);
		end else begin
			dec_in_word = 1'b0;
		end
	endfunction

	// Validate a completed multi-byte sequence; drop overlong, surrogate, too large
	function automatic void close_sequence();
		logic [CP_W-1:0] c;
		logic ok;
		c = dec_cp;
		ok = 1'b1;
		if (dec_len == SEQ_TWO && c < 21'h80)
			ok = 1'b0;
		if (dec_len == SEQ_THREE && (c < 21'h800 || (c >= 21'hD800 && c <= 21'hDFFF)))
			ok = 1'b0;
		if (dec_len == SEQ_FOUR && (c < 21'h10000 || c > 21'h10FFFF))
			ok = 1'b0;
		dec_cp = '0;
		dec_len = SEQ_NONE;
		if (ok)
			count_codepoint(c);
	endfunction

	// Decode a byte met in start position; bad start bytes are dropped
	function automatic void open_sequence(input logic [BYTE_W-1:0] b);
		if (!b[7]) begin
			count_codepoint({13'd0, b});
		end else if (b[7:5] == 3'b110) begin
			dec_cp = {16'd0, b[4:0]};
			dec_left = 2'd1;
			dec_len = SEQ_TWO;
		end else if (b[7:4] == 4'b1110) begin
			dec_cp = {17'd0, b[3:0]};
			dec_left = 2'd2;
			dec_len = SEQ_THREE;
		end else if (b[7:3] == 5'b11110) begin
			dec_cp = {18'd0, b[2:0]};
			dec_left = 2'd3;
			dec_len = SEQ_FOUR;
		end
	endfunction

	function automatic void clear_decoder();
		dec_cp = '0;
		dec_left = '0;
		dec_len = SEQ_NONE;
		dec_in_word = 1'b0;
		running_tally = '0;
	endfunction

	// Advance the decoder by one transferred byte; queue the counts on a last byte
	function automatic void predict_byte(input logic [BYTE_W-1:0] b, input logic ends);
		if (dec_left != 0 && b[7:6] == 2'b10) begin
			dec_cp = (dec_cp << 6) | {15'd0, b[5:0]};
			dec_left = dec_left - 1'b1;
			if (dec_left == 0)
				close_sequence();
		end else begin
			// abandon any partial sequence, then treat as a start byte
			dec_left = '0;
			dec_len = SEQ_NONE;
			dec_cp = '0;
			open_sequence(b);
		end
		if (ends) begin
			expected_counts.push_back(running_tally);
			clear_decoder();
		end
	endfunction

	function automatic string tally_name(input int k);
		case (k)
			T_IDEO:   return "ideograph_count";
			T_PUNCT:  return "punctuation_count";
			T_WORDS:  return "word_count";
			T_WCHARS: return "word_char_count";
			default:  return "codepoint_count";
		endcase
	endfunction

	// Compare one count transfer with the oldest expectation
	function automatic void check_counts();
		tally_set_t seen;
		tally_set_t want;
		seen[T_IDEO]   = ideograph_count;
		seen[T_PUNCT]  = punctuation_count;
		seen[T_WORDS]  = word_count;
		seen[T_WCHARS] = word_char_count;
		seen[T_TOTAL]  = codepoint_count;
		if (expected_counts.size() == 0) begin
			$display("%0t: unexpected count transfer, expected none, got %h", $time, seen);
			mismatches++;
		end else begin
			want = expected_counts.pop_front();
			counts_checked++;
			for (int k = 0; k < 5; k++)
				if (seen[k] !== want[k]) begin
					$display("%0t: %s mismatch, expected %0d, got %0d",
					         $time, tally_name(k), want[k], seen[k]);
					mismatches++;
				end
		end
	endfunction

	// ------------------------------------------------------------------
	// Monitor and watchdog
	// ------------------------------------------------------------------
	always @(posedge clk) begin
		if (arst_n) begin
			if (byte_valid && !byte_stall) begin
				predict_byte(byte_value, last_byte);
				bytes_taken++;
			end
			if (count_valid && !count_stall)
				check_counts();
			if ((byte_valid && !byte_stall) || (count_valid && !count_stall)) begin
				quiet_cycles = 0;
			end else begin
				quiet_cycles++;
				if (quiet_cycles >= QUIET_LIMIT) begin
					$display("%0t: no transfer for %0d cycles", $time, QUIET_LIMIT);
					$display("FAILURE");
					$finish;
				end
			end
		end
	end

	// Count side: hold off while a long stall is requested, else stall at random
	always @(negedge clk) begin
		if (hold_left > 0) begin
			count_stall <= 1'b1;
			hold_left = hold_left - 1;
		end else begin
			count_stall <= ($urandom_range(99) < recv_idle_pct);
		end
	end

	// ------------------------------------------------------------------
	// Stimulus helpers
	// ------------------------------------------------------------------

	// Offer one byte, idling first at random; return at the falling edge after
	task automatic send_byte(input logic [BYTE_W-1:0] b, input logic ends);
		while ($urandom_range(99) < send_idle_pct) begin
			byte_valid <= 1'b0;
			@(negedge clk);
		end
		byte_valid <= 1'b1;
		byte_value <= b;
		last_byte <= ends;
		do @(posedge clk); while (byte_stall);
		@(negedge clk);
	endtask

	task automatic send_string();
		for (int i = 0; i < str_bytes.size(); i++)
			send_byte(str_bytes[i], i == str_bytes.size() - 1);
		strings_sent++;
	endtask

	// Withdraw the byte offer and wait for every outstanding count set
	task automatic wait_for_counts();
		while (expected_counts.size() != 0) begin
			byte_valid <= 1'b0;
			@(negedge clk);
		end
	endtask

	// Change idle rates between edges so neither side races the update
	task automatic set_idle(input int s_pct, input int r_pct);
		@(posedge clk);
		send_idle_pct = s_pct;
		recv_idle_pct = r_pct;
		@(negedge clk);
	endtask

	function automatic int natural_len(input logic [CP_W-1:0] c);
		if (c < 21'h80)
			return 1;
		if (c < 21'h800)
			return 2;
		if (c < 21'h10000)
			return 3;
		return 4;
	endfunction

	// Encode a code point in a given length; a longer one gives an overlong form
	function automatic void put_cp(input logic [CP_W-1:0] c, input int len);
		case (len)
			1: str_bytes.push_back({1'b0, c[6:0]});
			2: begin
				str_bytes.push_back({3'b110, c[10:6]});
				str_bytes.push_back({2'b10, c[5:0]});
			end
			3: begin
				str_bytes.push_back({4'b1110, c[15:12]});
				str_bytes.push_back({2'b10, c[11:6]});
				str_bytes.push_back({2'b10, c[5:0]});
			end
			default: begin
				str_bytes.push_back({5'b11110, c[20:18]});
				str_bytes.push_back({2'b10, c[17:12]});
				str_bytes.push_back({2'b10, c[11:6]});
				str_bytes.push_back({2'b10, c[5:0]});
			end
		endcase
	endfunction

	// Append one piece of text: mostly well-formed, some broken, some noise
	function automatic void add_piece();
		int r;
		int i;
		int n;
		logic [CP_W-1:0] c;
		r = $urandom_range(99);
		if (r < 22) begin
			n = $urandom_range(1, 5);
			repeat (n) begin
				case ($urandom_range(3))
					0: str_bytes.push_back(8'(int'("a") + $urandom_range(25)));
					1: str_bytes.push_back(8'(int'("A") + $urandom_range(25)));
					2: str_bytes.push_back(8'(int'("0") + $urandom_range(9)));
					default: str_bytes.push_back(8'h27);
				endcase
			end
		end else if (r < 30) begin
			str_bytes.push_back(8'($urandom_range(127)));
		end else if (r < 44) begin
			i = $urandom_range(7);
			case ($urandom_range(3))
				0: c = IDEO_LO[i];
				1: c = IDEO_HI[i];
				2: c = IDEO_LO[i] + CP_W'($urandom_range(IDEO_HI[i] - IDEO_LO[i]));
				default: c = $urandom_range(1) ? IDEO_LO[i] - 1'b1 : IDEO_HI[i] + 1'b1;
			endcase
			put_cp(c, natural_len(c));
		end else if (r < 54) begin
			c = {5'd0, HAN_PUNCT[$urandom_range(PUNCT_N - 1)]};
			if ($urandom_range(3) == 0)
				c = $urandom_range(1) ? c + 1'b1 : c - 1'b1;
			put_cp(c, natural_len(c));
		end else if (r < 64) begin
			c = $urandom_range(1) ? PLANE_EDGES[$urandom_range(7)]
			                      : CP_W'($urandom_range(21'h80, 21'h10FFFF));
			put_cp(c, natural_len(c));
		end else if (r < 70) begin
			// overlong form
			c = $urandom_range(1) ? CP_W'($urandom_range(21'hFFFF))
			                      : PLANE_EDGES[$urandom_range(5)];
			put_cp(c, $urandom_range(natural_len(c) + 1, 4));
		end else if (r < 74) begin
			put_cp(CP_W'($urandom_range(21'hD800, 21'hDFFF)), 3);
		end else if (r < 78) begin
			put_cp(CP_W'($urandom_range(21'h110000, 21'h1FFFFF)), 4);
		end else if (r < 84) begin
			str_bytes.push_back($urandom_range(1) ? 8'($urandom_range(8'h80, 8'hBF))
			                                      : 8'($urandom_range(8'hF8, 8'hFF)));
		end else if (r < 92) begin
			// cut a multi-byte sequence short
			c = CP_W'($urandom_range(21'h80, 21'h10FFFF));
			n = natural_len(c);
			put_cp(c, n);
			repeat ($urandom_range(1, n - 1))
				void'(str_bytes.pop_back());
		end else begin
			str_bytes.push_back(8'($urandom_range(255)));
		end
	endfunction

	// ------------------------------------------------------------------
	// Tests
	// ------------------------------------------------------------------

	// Edge bytes and every malformed form, in three short strings
	task automatic test_directed();
		str_bytes = '{8'h7F};
		send_string();
		// word run across a bad start byte, then an ideograph
		str_bytes = '{8'h00, "a", 8'h27, 8'h80, "Z", 8'hE4, 8'hB8, 8'h80};
		send_string();
		// overlong, surrogate, too large, bad start, missing continuation,
		// then a sequence cut off at the end of the string
		str_bytes = '{8'hC0, 8'h80, 8'hED, 8'hA0, 8'h80, 8'hF4, 8'h90, 8'h80, 8'h80,
		              8'hFF, 8'hE3, 8'h80, "9", 8'hF0, 8'h9F};
		send_string();
		wait_for_counts();
	endtask

	task automatic test_random_text(input int n_bytes);
		int sent;
		sent = 0;
		while (sent < n_bytes) begin
			str_bytes.delete();
			repeat ($urandom_range(1, 8))
				add_piece();
			sent += str_bytes.size();
			send_string();
		end
		wait_for_counts();
	endtask

	// Hold the count side off while short strings keep arriving
	task automatic test_count_hold_off();
		@(posedge clk);
		hold_left = HOLD_CYCLES;
		@(negedge clk);
		repeat (60) begin
			str_bytes.delete();
			add_piece();
			send_string();
		end
		// pause until every count has come back
		wait_for_counts();
	endtask

	initial begin
		arst_n = 1'b0;
		byte_valid = 1'b0;
		byte_value = '0;
		last_byte = 1'b0;
		count_stall = 1'b0;
		send_idle_pct = 0;
		recv_idle_pct = 0;
		hold_left = 0;
		quiet_cycles = 0;
		mismatches = 0;
		bytes_taken = 0;
		strings_sent = 0;
		counts_checked = 0;
		clear_decoder();
		repeat (2) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		set_idle(29, 53);
		test_directed();
		test_random_text(PHASE_BYTES);
		set_idle(53, 29);
		test_random_text(PHASE_BYTES);
		set_idle(0, 0);
		test_count_hold_off();
		test_random_text(PHASE_BYTES);

		// drain and allow for the pipeline latency
		byte_valid <= 1'b0;
		wait_for_counts();
		repeat (8) @(posedge clk);
		if (expected_counts.size() != 0) begin
			$display("%0t: %0d count sets never arrived", $time, expected_counts.size());
			mismatches++;
		end
		$display("Streamed %0d bytes in %0d strings, %0d count sets checked, %0d mismatches;",
		         bytes_taken, strings_sent, counts_checked, mismatches);
		$display("covered malformed UTF-8, class edges, three idle mixes and a count hold-off");
		if (mismatches == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule
